@@ sv/astm_fr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASTM frame receiver package
// Character codes, result kind and error codes, and the result record shared
// by the parser and the output stage.
// ----------------------------------------------------------------------------
package astm_fr_pkg;

    localparam int unsigned MAX_BODY = 240;

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ETB = 8'h17;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_NO_STX    = 4'd1,
        ERR_BAD_DIGIT = 4'd2,
        ERR_TOO_LONG  = 4'd3,
        ERR_HEX_HI    = 4'd4,
        ERR_HEX_LO    = 4'd5,
        ERR_NO_CR     = 4'd6,
        ERR_NO_LF     = 4'd7,
        ERR_CHECKSUM  = 4'd8
    } err_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [2:0] frame_number;
        logic       intermediate;
        err_t       error_code;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            h.value = 4'(c - CH_ZERO);
        end
        else if (c >= CH_LC_A && c <= CH_LC_F)
        begin
            h.value = 4'(c - CH_LC_A + 8'd10);
        end
        else if (c >= CH_UC_A && c <= CH_UC_F)
        begin
            h.value = 4'(c - CH_UC_A + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ sv/astm_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASTM frame receiver
// Takes one character per beat and emits body bytes, frame completion and
// framing errors.
// ----------------------------------------------------------------------------
// A result reaches the master side through the input register and then the
// result register.
// Throughput: one character per cycle; the parser state updates once per
// character and a stalled output only holds characters that produce a result.
// Reset: rst_n clears the phase to idle and all frame state to zero.
module astm_frame_receiver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] frame_number,
                                        // [11] intermediate, [15:12] error_code
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import astm_fr_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       take;
    logic       emit;
    logic       free;
    result_t    res;
    result_t    out_res;

    // advance when the result, if any, has room downstream
    assign take = held_valid && (free || !emit);

    astm_fr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    astm_fr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (take),
        .rx_byte (held_byte),
        .emit    (emit),
        .res     (res)
    );

    astm_fr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && emit),
        .res       (res),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.error_code, out_res.intermediate,
                           out_res.frame_number, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

@@ sv/astm_fr_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASTM frame receiver input stage
// Registers one received character and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module astm_fr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);
    logic       valid_reg;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    // a held beat is only dropped once the parser has consumed it
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg && $stable(byte_reg))
        else $error("held character lost before use");

    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> valid_reg)
        else $error("parser took an empty input stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("empty input stage not ready");

endmodule

@@ sv/astm_fr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASTM frame parser
// Frame state machine: tracks the phase, frame digit, checksum and body
// length, and forms at most one result per character.
// ----------------------------------------------------------------------------
module astm_fr_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [7:0]           rx_byte,
    output logic                 emit,
    output astm_fr_pkg::result_t res
);
    import astm_fr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DIGIT = 3'd1,
        PH_BODY  = 3'd2,
        PH_HEXHI = 3'd3,
        PH_HEXLO = 3'd4,
        PH_CR    = 3'd5,
        PH_LF    = 3'd6
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] digit_reg, digit_next;
    logic [7:0] sum_reg, sum_next;
    logic       cr_seen_reg, cr_seen_next;
    logic       etb_reg, etb_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] rsum_reg, rsum_next;
    logic       has_data_reg, has_data_next;
    hex_t       hex;
    logic       is_etb;

    assign hex    = hex_decode(rx_byte);
    assign is_etb = (rx_byte == CH_ETB);

    always_comb
    begin
        phase_next    = phase_reg;
        digit_next    = digit_reg;
        sum_next      = sum_reg;
        cr_seen_next  = cr_seen_reg;
        etb_next      = etb_reg;
        count_next    = count_reg;
        rsum_next     = rsum_reg;
        has_data_next = has_data_reg;
        emit             = 1'b0;
        res.kind         = KIND_ERROR;
        res.data_byte    = 8'd0;
        res.frame_number = digit_reg;
        res.intermediate = 1'b0;
        res.error_code   = ERR_NONE;

        case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == CH_STX)
                begin
                    phase_next = PH_DIGIT;
                end
                else if (rx_byte != CH_EOT)
                begin
                    emit             = 1'b1;
                    res.error_code   = ERR_NO_STX;
                    res.frame_number = 3'd0;
                end
            end
            PH_DIGIT:
            begin
                if (rx_byte inside {[CH_ZERO:CH_SEVEN]})
                begin
                    // low three bits of '0'..'7' are the digit itself
                    digit_next    = rx_byte[2:0];
                    sum_next      = rx_byte;
                    cr_seen_next  = 1'b0;
                    etb_next      = 1'b0;
                    count_next    = 8'd0;
                    rsum_next     = 8'd0;
                    has_data_next = 1'b0;
                    phase_next    = PH_BODY;
                end
                else
                begin
                    emit             = 1'b1;
                    res.error_code   = ERR_BAD_DIGIT;
                    res.frame_number = 3'd0;
                    phase_next       = PH_IDLE;
                end
            end
            PH_BODY:
            begin
                if (is_etb || rx_byte == CH_ETX)
                begin
                    etb_next = is_etb;
                    sum_next = sum_reg + rx_byte + (cr_seen_reg ? CH_CR : 8'd0);
                    if (!has_data_reg)
                    begin
                        emit             = 1'b1;
                        res.kind         = KIND_FRAME;
                        res.intermediate = is_etb;
                        phase_next       = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_HEXHI;
                    end
                end
                else if (count_reg >= 8'(MAX_BODY))
                begin
                    emit           = 1'b1;
                    res.error_code = ERR_TOO_LONG;
                    phase_next     = PH_IDLE;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                    if (rx_byte == CH_CR)
                    begin
                        // drop the CR, remember it for the checksum
                        cr_seen_next = 1'b1;
                    end
                    else
                    begin
                        has_data_next = 1'b1;
                        sum_next      = sum_reg + rx_byte;
                        emit          = 1'b1;
                        res.kind      = KIND_DATA;
                        res.data_byte = rx_byte;
                    end
                end
            end
            PH_HEXHI:
            begin
                if (hex.ok)
                begin
                    rsum_next  = {hex.value, 4'd0};
                    phase_next = PH_HEXLO;
                end
                else
                begin
                    emit           = 1'b1;
                    res.error_code = ERR_HEX_HI;
                    phase_next     = PH_IDLE;
                end
            end
            PH_HEXLO:
            begin
                if (hex.ok)
                begin
                    rsum_next  = {rsum_reg[7:4], hex.value};
                    phase_next = PH_CR;
                end
                else
                begin
                    emit           = 1'b1;
                    res.error_code = ERR_HEX_LO;
                    phase_next     = PH_IDLE;
                end
            end
            PH_CR:
            begin
                if (rx_byte == CH_CR)
                begin
                    phase_next = PH_LF;
                end
                else
                begin
                    emit           = 1'b1;
                    res.error_code = ERR_NO_CR;
                    phase_next     = PH_IDLE;
                end
            end
            PH_LF:
            begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
                if (rx_byte != CH_LF)
                begin
                    res.error_code = ERR_NO_LF;
                end
                else if (rsum_reg != sum_reg)
                begin
                    res.error_code = ERR_CHECKSUM;
                end
                else
                begin
                    res.kind         = KIND_FRAME;
                    res.intermediate = etb_reg;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            digit_reg    <= 3'd0;
            sum_reg      <= 8'd0;
            cr_seen_reg  <= 1'b0;
            etb_reg      <= 1'b0;
            count_reg    <= 8'd0;
            rsum_reg     <= 8'd0;
            has_data_reg <= 1'b0;
        end
        else if (go)
        begin
            phase_reg    <= phase_next;
            digit_reg    <= digit_next;
            sum_reg      <= sum_next;
            cr_seen_reg  <= cr_seen_next;
            etb_reg      <= etb_next;
            count_reg    <= count_next;
            rsum_reg     <= rsum_next;
            has_data_reg <= has_data_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        go && emit && res.kind == KIND_ERROR |=> phase_reg == PH_IDLE)
        else $error("error result did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 8'(MAX_BODY))
        else $error("body count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        go && emit && res.kind == KIND_DATA |=> has_data_reg && phase_reg == PH_BODY)
        else $error("data beat without body state");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit && (res.error_code == ERR_NO_STX || res.error_code == ERR_BAD_DIGIT)
        |-> res.frame_number == 3'd0)
        else $error("frame number set on framing error");

endmodule

@@ sv/astm_fr_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASTM frame receiver output stage
// Result register on the master side; loads a new result whenever it is
// empty or its current beat is taken in the same cycle.
// ----------------------------------------------------------------------------
module astm_fr_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  astm_fr_pkg::result_t res,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output astm_fr_pkg::result_t out_res
);
    import astm_fr_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            res_reg <= res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result loaded over a pending beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(res_reg))
        else $error("pending result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.kind != KIND_DATA |-> res_reg.data_byte == 8'd0)
        else $error("data byte set on non-data result");

endmodule

@@ test/astm_frame_receiver_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASTM frame receiver testbench
// Streams characters into the receiver and checks every result beat against a
// frame parser kept in the bench. The run covers directed frames, randomized
// well-formed frames with injected faults, and line noise. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module astm_frame_receiver_unit_tb;

    import astm_fr_pkg::*;

    localparam int RANDOM_ITEMS   = 750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {
        RX_IDLE,
        RX_DIGIT,
        RX_BODY,
        RX_HEX_HI,
        RX_HEX_LO,
        RX_CR,
        RX_LF
    } rx_phase_e;

    typedef enum int {
        FLT_NONE,
        FLT_DIGIT,
        FLT_HEX_HI,
        FLT_HEX_LO,
        FLT_NO_CR,
        FLT_NO_LF,
        FLT_SUM
    } fault_e;

    // Tracks the frame state of the link and the results it must produce.
    class frame_result_tracker;
        rx_phase_e   phase;
        logic [2:0]  digit;
        logic [7:0]  sum;
        logic [7:0]  rx_sum;
        bit          cr_flag;
        bit          etb_flag;
        bit          has_data;
        int          body_len;
        result_t     expected_results[$];
        int          mismatches;

        function new();
            phase      = RX_IDLE;
            digit      = 3'd0;
            sum        = 8'd0;
            rx_sum     = 8'd0;
            cr_flag    = 1'b0;
            etb_flag   = 1'b0;
            has_data   = 1'b0;
            body_len   = 0;
            mismatches = 0;
        endfunction

        static function bit nibble_of(input logic [7:0] c, output logic [3:0] v);
            v = 4'd0;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                v = c[3:0];
                return 1'b1;
            end
            if ((c >= CH_UC_A && c <= CH_UC_F) || (c >= CH_LC_A && c <= CH_LC_F))
            begin
                v = 4'(c[2:0] + 4'd9);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void queue_result(kind_t k, logic [7:0] d, logic [2:0] fnum,
                                   bit inter, err_t e);
            result_t r;
            r.kind         = k;
            r.data_byte    = d;
            r.frame_number = fnum;
            r.intermediate = inter;
            r.error_code   = e;
            expected_results.push_back(r);
        endfunction

        function void abort_frame(err_t e, logic [2:0] fnum);
            phase = RX_IDLE;
            queue_result(KIND_ERROR, 8'h00, fnum, 1'b0, e);
        endfunction

        function void note_byte(input logic [7:0] b);
            logic [3:0] v;
            case (phase)
                RX_IDLE:
                begin
                    if (b == CH_STX)
                    begin
                        phase = RX_DIGIT;
                    end
                    else if (b != CH_EOT)
                    begin
                        abort_frame(ERR_NO_STX, 3'd0);
                    end
                end
                RX_DIGIT:
                begin
                    if (b < CH_ZERO || b > CH_SEVEN)
                    begin
                        abort_frame(ERR_BAD_DIGIT, 3'd0);
                    end
                    else
                    begin
                        digit    = b[2:0];
                        sum      = b;
                        cr_flag  = 1'b0;
                        etb_flag = 1'b0;
                        has_data = 1'b0;
                        body_len = 0;
                        rx_sum   = 8'd0;
                        phase    = RX_BODY;
                    end
                end
                RX_BODY:
                begin
                    if (b == CH_ETB || b == CH_ETX)
                    begin
                        etb_flag = (b == CH_ETB);
                        sum      = sum + b + (cr_flag ? CH_CR : 8'h00);
                        if (!has_data)
                        begin
                            // empty body: frame is done, no checksum follows
                            phase = RX_IDLE;
                            queue_result(KIND_FRAME, 8'h00, digit, etb_flag, ERR_NONE);
                        end
                        else
                        begin
                            phase = RX_HEX_HI;
                        end
                    end
                    else if (body_len >= MAX_BODY)
                    begin
                        abort_frame(ERR_TOO_LONG, digit);
                    end
                    else
                    begin
                        body_len++;
                        if (b == CH_CR)
                        begin
                            cr_flag = 1'b1;
                        end
                        else
                        begin
                            has_data = 1'b1;
                            sum      = sum + b;
                            queue_result(KIND_DATA, b, digit, 1'b0, ERR_NONE);
                        end
                    end
                end
                RX_HEX_HI:
                begin
                    if (!nibble_of(b, v))
                    begin
                        abort_frame(ERR_HEX_HI, digit);
                    end
                    else
                    begin
                        rx_sum = {v, 4'h0};
                        phase  = RX_HEX_LO;
                    end
                end
                RX_HEX_LO:
                begin
                    if (!nibble_of(b, v))
                    begin
                        abort_frame(ERR_HEX_LO, digit);
                    end
                    else
                    begin
                        rx_sum[3:0] = v;
                        phase       = RX_CR;
                    end
                end
                RX_CR:
                begin
                    if (b != CH_CR)
                    begin
                        abort_frame(ERR_NO_CR, digit);
                    end
                    else
                    begin
                        phase = RX_LF;
                    end
                end
                RX_LF:
                begin
                    if (b != CH_LF)
                    begin
                        abort_frame(ERR_NO_LF, digit);
                    end
                    else if (rx_sum != sum)
                    begin
                        abort_frame(ERR_CHECKSUM, digit);
                    end
                    else
                    begin
                        phase = RX_IDLE;
                        queue_result(KIND_FRAME, 8'h00, digit, etb_flag, ERR_NONE);
                    end
                end
                default:
                begin
                    phase = RX_IDLE;
                end
            endcase
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected result: kind %0d data %02h frame %0d inter %0d err %0d",
                             got.kind, got.data_byte, got.frame_number, got.intermediate,
                             got.error_code);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.kind != want.kind || got.data_byte != want.data_byte ||
                got.frame_number != want.frame_number ||
                got.intermediate != want.intermediate || got.error_code != want.error_code)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("mismatch: expected kind %0d data %02h frame %0d inter %0d err %0d",
                             want.kind, want.data_byte, want.frame_number, want.intermediate,
                             want.error_code);
                    $display("          actual   kind %0d data %02h frame %0d inter %0d err %0d",
                             got.kind, got.data_byte, got.frame_number, got.intermediate,
                             got.error_code);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    frame_result_tracker tracker = new();

    logic [7:0] body_bytes[$];
    logic [7:0] frame_bytes[$];
    bit         tx_burst = 1'b0;

    astm_frame_receiver_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return CH_ZERO + n;
        end
        return ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] v;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (frame_result_tracker::nibble_of(c, v));
        return c;
    endfunction

    function automatic logic [7:0] any_char_but(input logic [7:0] x);
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == x);
        return c;
    endfunction

    // Body byte that neither ends the frame nor counts as a body CR.
    function automatic logic [7:0] plain_body_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == CH_ETB || c == CH_ETX || c == CH_CR);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        tracker.note_byte(b);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
        begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // Hold the sender until every pending result beat has drained.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (tracker.pending() != 0);
    endtask

    // Build a frame of body_bytes; faults but FLT_SUM cut it at the bad character.
    task automatic build_frame(input logic [7:0] digit_ch, input bit etb, input fault_e fault);
        logic [7:0] sum;
        logic [7:0] term;
        bit         cr_any;
        bit         has_data;
        frame_bytes.delete();
        frame_bytes.push_back(CH_STX);
        if (fault == FLT_DIGIT)
        begin
            do
            begin
                digit_ch = 8'($urandom_range(0, 255));
            end
            while (digit_ch >= CH_ZERO && digit_ch <= CH_SEVEN);
            frame_bytes.push_back(digit_ch);
            return;
        end
        frame_bytes.push_back(digit_ch);
        sum      = digit_ch;
        cr_any   = 1'b0;
        has_data = 1'b0;
        foreach (body_bytes[i])
        begin
            frame_bytes.push_back(body_bytes[i]);
            if (body_bytes[i] == CH_CR)
            begin
                cr_any = 1'b1;
            end
            else
            begin
                has_data = 1'b1;
                sum      = sum + body_bytes[i];
            end
        end
        term = etb ? CH_ETB : CH_ETX;
        frame_bytes.push_back(term);
        if (!has_data)
        begin
            return;
        end
        sum = sum + term + (cr_any ? CH_CR : 8'h00);
        if (fault == FLT_SUM)
        begin
            sum = sum ^ (8'h01 << $urandom_range(0, 7));
        end
        if (fault == FLT_HEX_HI)
        begin
            frame_bytes.push_back(non_hex_char());
            return;
        end
        frame_bytes.push_back(hex_char(sum[7:4]));
        if (fault == FLT_HEX_LO)
        begin
            frame_bytes.push_back(non_hex_char());
            return;
        end
        frame_bytes.push_back(hex_char(sum[3:0]));
        if (fault == FLT_NO_CR)
        begin
            frame_bytes.push_back(any_char_but(CH_CR));
            return;
        end
        frame_bytes.push_back(CH_CR);
        frame_bytes.push_back(fault == FLT_NO_LF ? any_char_but(CH_LF) : CH_LF);
    endtask

    // Result side: check each beat, then pick the next ready level.
    initial
    begin
        int stall;
        bit rx_burst;
        result_t got;
        stall    = 0;
        rx_burst = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.kind         = kind_t'(m_axis_tuser);
                got.data_byte    = m_axis_tdata[7:0];
                got.frame_number = m_axis_tdata[10:8];
                got.intermediate = m_axis_tdata[11];
                got.error_code   = err_t'(m_axis_tdata[15:12]);
                tracker.check_result(got);
            end
            if ($urandom_range(0, 199) == 0)
            begin
                rx_burst = !rx_burst;
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_burst || $urandom_range(0, 99) < 70)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int     random_items;
        int     frame_idx;
        int     n_body;
        int     n_noise;
        bit     long_frame;
        fault_e fault;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle handling: EOT is dropped, anything else but STX is an error
        send_byte(CH_EOT);
        send_byte(8'hFF);

        // extreme body values plus a body CR, ended with ETB
        body_bytes = '{8'h00, 8'hFF, CH_CR};
        build_frame(CH_ZERO, 1'b1, FLT_NONE);
        send_frame();

        // empty body, and a body holding only a CR: both end at the terminator
        body_bytes.delete();
        build_frame(CH_SEVEN, 1'b1, FLT_NONE);
        send_frame();
        body_bytes = '{CH_CR};
        build_frame(CH_ZERO + 8'd3, 1'b0, FLT_NONE);
        send_frame();

        send_byte(CH_STX);
        send_byte(CH_SEVEN + 8'd1);

        body_bytes = '{8'h41};
        build_frame(CH_ZERO + 8'd5, 1'b0, FLT_SUM);
        send_frame();

        wait_for_results();

        random_items = 0;
        frame_idx    = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                n_noise = $urandom_range(1, 3);
                repeat (n_noise)
                begin
                    send_byte(($urandom_range(0, 3) == 0) ? CH_EOT : 8'($urandom_range(0, 255)));
                end
                random_items += n_noise;
            end
            else
            begin
                long_frame = (frame_idx == 3 || frame_idx == 8);
                if (frame_idx == 3)
                begin
                    n_body = MAX_BODY;
                end
                else if (frame_idx == 8)
                begin
                    // one byte past the limit
                    n_body = MAX_BODY + 1;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    n_body = $urandom_range(0, 2);
                end
                else
                begin
                    n_body = $urandom_range(1, 12);
                end
                if (long_frame || $urandom_range(0, 99) < 65)
                begin
                    fault = FLT_NONE;
                end
                else
                begin
                    fault = fault_e'($urandom_range(FLT_DIGIT, FLT_SUM));
                end
                body_bytes.delete();
                repeat (n_body)
                begin
                    body_bytes.push_back(($urandom_range(0, 99) < 8) ? CH_CR : plain_body_char());
                end
                build_frame(CH_ZERO + 8'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                            fault);
                send_frame();
                random_items += frame_bytes.size();
                frame_idx++;
                if (frame_idx % 16 == 0)
                begin
                    wait_for_results();
                end
            end
        end

        tx_burst = 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", tracker.mismatches,
                     tracker.pending());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/astm_fr_pkg.sv
sv/astm_fr_in_stage.sv
sv/astm_fr_parser.sv
sv/astm_fr_out_stage.sv
sv/astm_frame_receiver_unit.sv
test/astm_frame_receiver_unit_tb.sv
